// ----- sv/uhcle_pkg.sv -----
`default_nettype none

package uhcle_pkg;

  // Longest line the editor holds, and the width of the length counter.
  localparam int unsigned LINE_MAX = 255;
  localparam int unsigned LEN_W    = $clog2(LINE_MAX + 1);

  // Only line positions 1 to 6 feed the color pairs, so only they are kept.
  localparam int unsigned LINE_KEEP  = 6;
  localparam int unsigned KEEP_IDX_W = $clog2(LINE_KEEP);

  // Depth of the command queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Character codes.
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_0     = 8'd48;
  localparam logic [7:0] CH_9     = 8'd57;
  localparam logic [7:0] CH_UA    = 8'd65;
  localparam logic [7:0] CH_UF    = 8'd70;
  localparam logic [7:0] CH_LA    = 8'd97;
  localparam logic [7:0] CH_LF_HEX = 8'd102;
  localparam logic [7:0] CH_DEL   = 8'd127;

  localparam logic [7:0] LEVEL_RESET = 8'd255;

  // Kind of work the back end carries out for one item.
  typedef enum logic [1:0] {
    CMD_CHAR = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_CR   = 2'd2
  } cmd_kind_t;

  // One entry of the command queue.
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] rx_byte;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cmd_t;

  // White space as the C library sees it: space, tab through return.
  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Hex digit decode: bit 4 flags a digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if ((c >= CH_0) && (c <= CH_9)) begin
      r = {1'b1, c[3:0]};
    end else if (((c >= CH_LA) && (c <= CH_LF_HEX)) || ((c >= CH_UA) && (c <= CH_UF))) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Reads a two-character pair as base 16, with optional white space and sign.
  // A character that is not valid stands for the end of the line.
  function automatic logic [7:0] pair_value(input logic [7:0] c0, input logic v0,
                                            input logic [7:0] c1, input logic v1);
    logic [7:0] ch [2];
    logic       vd [2];
    logic [1:0] idx;
    logic       neg;
    logic [7:0] acc;
    logic [4:0] hd;
    ch[0] = c0;
    ch[1] = c1;
    vd[0] = v0;
    vd[1] = v1 & v0;
    idx   = 2'd0;
    neg   = 1'b0;
    acc   = 8'd0;
    for (int k = 0; k < 2; k++) begin
      if ((idx == 2'(k)) && vd[k] && is_ws(ch[k])) begin
        idx = idx + 2'd1;
      end
    end
    for (int k = 0; k < 2; k++) begin
      if ((idx == 2'(k)) && vd[k] && ((ch[k] == CH_PLUS) || (ch[k] == CH_MINUS))) begin
        neg = (ch[k] == CH_MINUS);
        idx = idx + 2'd1;
      end
    end
    for (int k = 0; k < 2; k++) begin
      hd = hex_digit(ch[k]);
      if ((idx == 2'(k)) && vd[k] && hd[4]) begin
        acc = {acc[3:0], hd[3:0]};
        idx = idx + 2'd1;
      end
    end
    if (neg) begin
      acc = 8'd0 - acc;
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// ----- sv/uhcle_front.sv -----
`default_nettype none

module uhcle_front
  import uhcle_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_push,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic q_full,
  output logic      q_push,
  output cmd_t      q_data
);

  logic [LEN_W-1:0] line_len_r, line_len_nxt;
  logic [7:0]       chars_r [LINE_KEEP];
  logic             accept;
  logic             is_del, is_cr;
  logic             line_empty, line_full;
  logic             do_append;
  logic [LEN_W-1:0] len_m1;
  logic [7:0]       red_val, green_val, blue_val;

  // Classify the incoming item.
  assign accept     = in_push && !q_full;
  assign is_del     = (in_rx_byte == CH_DEL);
  assign is_cr      = (in_rx_byte == CH_CR);
  assign line_empty = (line_len_r == '0);
  assign line_full  = (line_len_r >= LEN_W'(LINE_MAX));
  assign do_append  = accept && !is_del && !is_cr && !line_full;
  assign len_m1     = line_len_r - 1'b1;

  // Parse the three color pairs from the held line; a position at or past
  // the line length reads as end of line.
  assign red_val   = pair_value(chars_r[0], line_len_r > LEN_W'(1),
                                chars_r[1], line_len_r > LEN_W'(2));
  assign green_val = pair_value(chars_r[2], line_len_r > LEN_W'(3),
                                chars_r[3], line_len_r > LEN_W'(4));
  assign blue_val  = pair_value(chars_r[4], line_len_r > LEN_W'(5),
                                chars_r[5], line_len_r > LEN_W'(6));

  // Line length bookkeeping.
  always_comb begin
    line_len_nxt = line_len_r;
    if (accept) begin
      if (is_cr) begin
        line_len_nxt = '0;
      end else if (is_del) begin
        if (!line_empty) begin
          line_len_nxt = len_m1;
        end
      end else if (!line_full) begin
        line_len_nxt = line_len_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r <= '0;
    end else begin
      line_len_r <= line_len_nxt;
    end
  end

  // Keep the characters at line positions 1 to 6.
  always_ff @(posedge clk) begin
    if (do_append && !line_empty && (line_len_r <= LEN_W'(LINE_KEEP))) begin
      chars_r[len_m1[KEEP_IDX_W-1:0]] <= in_rx_byte;
    end
  end

  // Hand work to the back end; ignored deletes and dropped bytes send nothing.
  always_comb begin
    q_push         = accept && (is_cr || (is_del && !line_empty) || do_append);
    q_data.rx_byte = in_rx_byte;
    q_data.red     = red_val;
    q_data.green   = green_val;
    q_data.blue    = blue_val;
    if (is_cr) begin
      q_data.kind = CMD_CR;
    end else if (is_del) begin
      q_data.kind = CMD_DEL;
    end else begin
      q_data.kind = CMD_CHAR;
    end
  end

endmodule

`default_nettype wire

// ----- sv/uhcle_queue.sv -----
`default_nettype none

module uhcle_queue
  import uhcle_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t din,
  input  wire logic pop,
  output cmd_t      dout,
  output logic      full,
  output logic      empty
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/uhcle_back.sv -----
`default_nettype none

module uhcle_back
  import uhcle_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_empty,
  input  wire cmd_t q_data,
  output logic      q_pop,
  input  wire logic out_pop,
  output logic      out_empty,
  output logic [7:0] out_echo_byte,
  output logic [7:0] out_red_duty,
  output logic [7:0] out_green_duty,
  output logic [7:0] out_blue_duty,
  output logic      out_indicator,
  output logic      out_last
);

  cmd_t       cur_r;
  logic       cur_valid_r;
  logic [1:0] step_r;
  logic [7:0] red_r, green_r, blue_r;
  logic       ind_r;
  logic       out_valid_r;
  logic [7:0] echo_r, ored_r, ogreen_r, oblue_r;
  logic       oind_r, olast_r;
  logic       out_ready, emit;
  logic [7:0] echo_val;
  logic       last_val;
  logic       load;

  assign out_ready = !out_valid_r || out_pop;
  assign emit      = cur_valid_r && out_ready;
  assign load      = !q_empty && (!cur_valid_r || (emit && last_val));
  assign q_pop     = load;

  // Echo sequence of the current item.
  always_comb begin
    unique case (cur_r.kind)
      CMD_DEL: begin
        echo_val = (step_r == 2'd1) ? CH_SP : CH_BS;
        last_val = (step_r == 2'd2);
      end
      CMD_CR: begin
        echo_val = (step_r == 2'd0) ? CH_LF : CH_CR;
        last_val = (step_r == 2'd1);
      end
      CMD_CHAR: begin
        echo_val = cur_r.rx_byte;
        last_val = 1'b1;
      end
      default: begin
        echo_val = cur_r.rx_byte;
        last_val = 1'b1;
      end
    endcase
  end

  // Current item and step; a return takes its new levels when it is loaded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= 2'd0;
      red_r       <= LEVEL_RESET;
      green_r     <= LEVEL_RESET;
      blue_r      <= LEVEL_RESET;
      ind_r       <= 1'b0;
    end else begin
      if (load) begin
        cur_valid_r <= 1'b1;
        step_r      <= 2'd0;
        if (q_data.kind == CMD_CR) begin
          red_r   <= q_data.red;
          green_r <= q_data.green;
          blue_r  <= q_data.blue;
          ind_r   <= !ind_r;
        end
      end else if (emit) begin
        if (last_val) begin
          cur_valid_r <= 1'b0;
        end else begin
          step_r <= step_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= cur_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      echo_r   <= echo_val;
      ored_r   <= red_r;
      ogreen_r <= green_r;
      oblue_r  <= blue_r;
      oind_r   <= ind_r;
      olast_r  <= last_val;
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_echo_byte  = echo_r;
  assign out_red_duty   = ored_r;
  assign out_green_duty = ogreen_r;
  assign out_blue_duty  = oblue_r;
  assign out_indicator  = oind_r;
  assign out_last       = olast_r;

endmodule

`default_nettype wire

// ----- sv/uart_hex_color_line_editor.sv -----
`default_nettype none

// Serial line editor that sets three color duties. Received bytes are
// pushed in one per cycle whenever full is low; the front end keeps the line
// and parses the color pairs on a return, and a two-entry command queue
// feeds the back end, which emits the echo results one per cycle through an
// output register as long as they are taken. A plain character gives one
// result, a return two and a delete on a non-empty line three. The first
// result of an item passes through the queue, the current-item register and
// the output register. A delete on an empty line and a byte arriving with
// the line full give no result. Duties reset to 255 and the indicator to 0.
module uart_hex_color_line_editor
  import uhcle_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       out_pop,
  output logic            out_empty,
  output logic [7:0]      out_echo_byte,
  output logic [7:0]      out_red_duty,
  output logic [7:0]      out_green_duty,
  output logic [7:0]      out_blue_duty,
  output logic            out_indicator,
  output logic            out_last
);

  logic q_push, q_pop, q_full, q_empty;
  cmd_t q_din, q_dout;

  assign in_full = q_full;

  uhcle_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_din)
  );

  uhcle_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  uhcle_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (q_dout),
    .q_pop          (q_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_echo_byte  (out_echo_byte),
    .out_red_duty   (out_red_duty),
    .out_green_duty (out_green_duty),
    .out_blue_duty  (out_blue_duty),
    .out_indicator  (out_indicator),
    .out_last       (out_last)
  );

  // The front end never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command pushed into a full queue");

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result visible after reset");

  // A result that is not taken stays on the ports unchanged.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_echo_byte) && $stable(out_last)))
    else $error("waiting result changed or vanished");

endmodule

`default_nettype wire

// ----- tb/sv/uart_hex_color_line_editor_tb.sv -----
module uart_hex_color_line_editor_tb
  import uhcle_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 4;
  localparam int RANDOM_ITEMS = 30;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 16;

  // One echoed byte together with the duties and indicator that go with it.
  typedef struct packed {
    logic [7:0] echo;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       ind;
    logic       last;
  } echo_item_t;

  // One directed item; when typed is set, first is the expected first result.
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    echo_item_t first;
  } stim_row_t;

  localparam echo_item_t NO_TYPE = '0;

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_push        = 1'b0;
  logic [7:0] in_rx_byte     = 8'd0;
  logic       out_pop        = 1'b0;
  logic       in_full;
  logic       out_empty;
  logic [7:0] out_echo_byte;
  logic [7:0] out_red_duty;
  logic [7:0] out_green_duty;
  logic [7:0] out_blue_duty;
  logic       out_indicator;
  logic       out_last;

  // Tags that travel with the item being offered, updated like in_push.
  logic       typed_row      = 1'b0;
  echo_item_t typed_first    = '0;

  int         send_idle_pct  = 21;
  int         recv_idle_pct  = 67;
  int         items_sent     = 0;
  int         mismatch_count = 0;
  int         cycle_count    = 0;

  echo_item_t echo_expect_q [$];

  // Editor state as the predictor sees it.
  int unsigned held_len  = 0;
  logic [7:0]  held_chars [LINE_KEEP];
  logic [7:0]  red_lvl   = LEVEL_RESET;
  logic [7:0]  green_lvl = LEVEL_RESET;
  logic [7:0]  blue_lvl  = LEVEL_RESET;
  logic        ind_lvl   = 1'b0;

  // Directed items: delete on an empty line, echo forms, empty pairs, hex of
  // both cases, a negated pair, sign and white space, zero and all-ones bytes,
  // and stale characters left behind by deletes.
  stim_row_t directed_rows [22] = '{
    '{CH_DEL, 1'b0, NO_TYPE},
    '{8'h41,  1'b1, '{8'h41, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1}},
    '{CH_DEL, 1'b1, '{CH_BS, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0}},
    '{CH_CR,  1'b1, '{CH_LF, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0}},
    '{8'h23,  1'b0, NO_TYPE},
    '{"F",    1'b0, NO_TYPE},
    '{"F",    1'b0, NO_TYPE},
    '{"a",    1'b0, NO_TYPE},
    '{"0",    1'b0, NO_TYPE},
    '{"-",    1'b0, NO_TYPE},
    '{"1",    1'b0, NO_TYPE},
    '{CH_CR,  1'b1, '{CH_LF, 8'hFF, 8'hA0, 8'hFF, 1'b0, 1'b0}},
    '{8'h00,  1'b0, NO_TYPE},
    '{"+",    1'b0, NO_TYPE},
    '{"f",    1'b0, NO_TYPE},
    '{CH_TAB, 1'b0, NO_TYPE},
    '{"9",    1'b0, NO_TYPE},
    '{"3",    1'b0, NO_TYPE},
    '{8'hFF,  1'b0, NO_TYPE},
    '{CH_DEL, 1'b0, NO_TYPE},
    '{CH_DEL, 1'b0, NO_TYPE},
    '{CH_CR,  1'b0, NO_TYPE}
  };

  uart_hex_color_line_editor DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_rx_byte     (in_rx_byte),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_echo_byte  (out_echo_byte),
    .out_red_duty   (out_red_duty),
    .out_green_duty (out_green_duty),
    .out_blue_duty  (out_blue_duty),
    .out_indicator  (out_indicator),
    .out_last       (out_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Character at a line position, or -1 past the line end or outside 1 to 6.
  function automatic int held_char(input int unsigned pos);
    if (pos == 0 || pos > LINE_KEEP || pos >= held_len) begin
      return -1;
    end
    return int'(held_chars[pos - 1]);
  endfunction

  function automatic bit is_space(input logic [7:0] c);
    return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Value of a hex digit of either case, or -1 for any other byte.
  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) begin
      return int'(c - CH_0);
    end
    if (c >= CH_LA && c <= CH_LF_HEX) begin
      return int'(c - CH_LA) + 10;
    end
    if (c >= CH_UA && c <= CH_UF) begin
      return int'(c - CH_UA) + 10;
    end
    return -1;
  endfunction

  // Duty from the pair at pos and pos+1: white space, a sign, then hex digits.
  function automatic logic [7:0] pair_duty(input int unsigned pos);
    int         ch [2];
    int         i;
    bit         neg;
    logic [7:0] acc;
    ch[0] = held_char(pos);
    ch[1] = (ch[0] < 0) ? -1 : held_char(pos + 1);
    i     = 0;
    neg   = 1'b0;
    acc   = 8'd0;
    while (i < 2 && ch[i] >= 0 && is_space(8'(ch[i]))) begin
      i++;
    end
    if (i < 2 && (ch[i] == int'(CH_PLUS) || ch[i] == int'(CH_MINUS))) begin
      neg = (ch[i] == int'(CH_MINUS));
      i++;
    end
    while (i < 2 && ch[i] >= 0 && hex_nibble(8'(ch[i])) >= 0) begin
      acc = 8'(acc * 16 + hex_nibble(8'(ch[i])));
      i++;
    end
    if (neg) begin
      acc = 8'd0 - acc;
    end
    return acc;
  endfunction

  function automatic echo_item_t echo_now(input logic [7:0] b, input logic fin);
    echo_item_t r;
    r.echo  = b;
    r.red   = red_lvl;
    r.green = green_lvl;
    r.blue  = blue_lvl;
    r.ind   = ind_lvl;
    r.last  = fin;
    return r;
  endfunction

  // Updates the editor state for one accepted byte and queues its echoes.
  function automatic void predict_echoes(input logic [7:0] c, input logic typed,
                                         input echo_item_t first);
    echo_item_t res [$];
    if (c == CH_DEL) begin
      if (held_len != 0) begin
        held_len--;
        res.push_back(echo_now(CH_BS, 1'b0));
        res.push_back(echo_now(CH_SP, 1'b0));
        res.push_back(echo_now(CH_BS, 1'b1));
      end
    end else if (c == CH_CR) begin
      red_lvl   = pair_duty(1);
      green_lvl = pair_duty(3);
      blue_lvl  = pair_duty(5);
      ind_lvl   = ~ind_lvl;
      held_len  = 0;
      res.push_back(echo_now(CH_LF, 1'b0));
      res.push_back(echo_now(CH_CR, 1'b1));
    end else if (held_len < LINE_MAX) begin
      if (held_len >= 1 && held_len <= LINE_KEEP) begin
        held_chars[held_len - 1] = c;
      end
      held_len++;
      res.push_back(echo_now(c, 1'b1));
    end
    if (typed && res.size() != 0) begin
      res[0] = first;
    end
    foreach (res[k]) begin
      echo_expect_q.push_back(res[k]);
    end
  endfunction

  // Prints one line per mismatch and counts every one.
  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("mismatch on %s: expected %0h, got %0h, cycle %0d",
             what, want, got, cycle_count);
    mismatch_count++;
  endtask

  task automatic check_echo();
    echo_item_t want;
    if (echo_expect_q.size() == 0) begin
      report_mismatch("result with nothing expected", 8'd0, out_echo_byte);
    end else begin
      want = echo_expect_q.pop_front();
      if (out_echo_byte !== want.echo) report_mismatch("echo_byte", want.echo, out_echo_byte);
      if (out_red_duty !== want.red) report_mismatch("red_duty", want.red, out_red_duty);
      if (out_green_duty !== want.green) begin
        report_mismatch("green_duty", want.green, out_green_duty);
      end
      if (out_blue_duty !== want.blue) report_mismatch("blue_duty", want.blue, out_blue_duty);
      if (out_indicator !== want.ind) begin
        report_mismatch("indicator", 8'(want.ind), 8'(out_indicator));
      end
      if (out_last !== want.last) report_mismatch("last", 8'(want.last), 8'(out_last));
    end
  endtask

  // Sampling at the rising edge sees the values from before the edge.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        predict_echoes(in_rx_byte, typed_row, typed_first);
      end
      if (out_pop && !out_empty) begin
        check_echo();
      end
      out_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Offers one byte after a random gap and returns at the edge that takes it.
  task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                           input echo_item_t first = '0);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push     <= 1'b1;
    in_rx_byte  <= b;
    typed_row   <= typed;
    typed_first <= first;
    do @(posedge clk); while (in_full);
    items_sent++;
  endtask

  function automatic logic [7:0] rand_plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_DEL || b == CH_CR);
    return b;
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int d;
    d = $urandom_range(0, 15);
    if (d < 10) begin
      return 8'(CH_0 + d);
    end
    return 8'((($urandom_range(0, 1) != 0) ? CH_LA : CH_UA) + d - 10);
  endfunction

  // A color command with random content: three pairs in various forms,
  // sometimes cut short or overlong, with typos fixed by deletes.
  task automatic send_color_line();
    logic [7:0] text [$];
    int         keep;
    int         pick;
    text.push_back(rand_plain_byte());
    repeat (3) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          text.push_back(rand_hex_char());
          text.push_back(rand_hex_char());
        end
        2: begin
          pick = $urandom_range(0, 4);
          text.push_back((pick == 0) ? CH_SP : 8'(CH_TAB + pick - 1));
          text.push_back(rand_hex_char());
        end
        3: begin
          text.push_back(($urandom_range(0, 1) != 0) ? CH_MINUS : CH_PLUS);
          text.push_back(rand_hex_char());
        end
        4: begin
          text.push_back(rand_hex_char());
          text.push_back(rand_plain_byte());
        end
        default: begin
          text.push_back(rand_plain_byte());
          text.push_back(rand_plain_byte());
        end
      endcase
    end
    if ($urandom_range(0, 4) == 0) begin
      keep = $urandom_range(0, text.size());
      while (text.size() > keep) void'(text.pop_back());
    end else if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 4)) text.push_back(rand_plain_byte());
    end
    foreach (text[k]) begin
      if ($urandom_range(0, 9) == 0) begin
        send_byte(rand_plain_byte());
        send_byte(CH_DEL);
      end
      send_byte(text[k]);
    end
    // Trailing deletes leave stale characters that must read as line end.
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(CH_DEL);
    end
    send_byte(CH_CR);
  endtask

  initial begin
    int target;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part.
    foreach (directed_rows[r]) begin
      send_byte(directed_rows[r].rx, directed_rows[r].typed, directed_rows[r].first);
    end

    // Random part in three idling phases; each starts after all echoes are in.
    for (int ph = 0; ph < 3; ph++) begin
      in_push <= 1'b0;
      while (echo_expect_q.size() != 0) @(posedge clk);
      case (ph)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct = 67;
        end
        1: begin
          send_idle_pct = 67;
          recv_idle_pct = 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      target = items_sent + RANDOM_ITEMS / 3;
      while (items_sent < target) begin
        if ($urandom_range(0, 3) != 0) begin
          send_color_line();
        end else begin
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        end
      end
      // Fill the line to its limit; the bytes beyond it are dropped.
      if (ph == 0) begin
        repeat (LINE_MAX + 4) send_byte(rand_plain_byte());
        send_byte(CH_DEL);
        send_byte(rand_plain_byte());
        send_byte(rand_plain_byte());
        send_byte(CH_CR);
      end
    end
    in_push <= 1'b0;

    // Drain and give late or extra results time to show up.
    while (echo_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
